/* hw/rtl/gpht_pkg.sv */
// Package for the grouped probe hash table.
// Holds command, status and register codes plus the word types.
// Used by the front, engine and top modules; depends on nothing.
package gpht_pkg;

  // Field widths fixed by the interface.
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int SLOT_W   = 10;
  localparam int TOTAL_W  = 11;
  localparam int CFG_W    = 10;
  localparam int TBITS_W  = 4;
  localparam int LIMIT_W  = 10;

  // Defaults for the top level parameters.
  localparam int SLOTS_DEF      = 1024;
  localparam int GROUP_DEF      = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  // Reset values of the configuration registers.
  localparam logic [TBITS_W-1:0] TBITS_RESET = 4'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd819;

  // Register indexes.
  localparam logic REG_TABLE_BITS = 1'b0;
  localparam logic REG_LOAD_LIMIT = 1'b1;

  // Input commands.
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Classified operations handed from front to back.
  localparam logic [1:0] OP_LOOKUP   = 2'd0;
  localparam logic [1:0] OP_INSERT   = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_HIT      = 3'd2;
  localparam logic [2:0] ST_MISS     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_RESERVED = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [VAL_W-1:0]   found_value;
    logic [SLOT_W-1:0]  slot_index;
    logic [TOTAL_W-1:0] entry_total;
  } out_word_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } item_t;

endpackage

/* hw/rtl/gpht_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module gpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/gpht_fifo.sv */
// Small generic FIFO used for the command and result queues.
// Depends on nothing.
module gpht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = buf_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/gpht_front.sv */
// Front part: accepts input words, classifies them and queues them.
// Depends on gpht_pkg and gpht_fifo.
module gpht_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  gpht_pkg::in_word_t in_word_i,
  output logic              full,
  input  logic              pop_i,
  output gpht_pkg::item_t   item_o,
  output logic              empty_o
);

  gpht_pkg::item_t item_in;

  // Clear wins; otherwise the all-ones key is refused; command 3 is a lookup.
  always_comb begin
    item_in.key   = in_word_i.key;
    item_in.value = in_word_i.value;
    if (in_word_i.cmd == gpht_pkg::CMD_CLEAR) begin
      item_in.op = gpht_pkg::OP_CLEAR;
    end else if (&in_word_i.key) begin
      item_in.op = gpht_pkg::OP_RESERVED;
    end else if (in_word_i.cmd == gpht_pkg::CMD_INSERT) begin
      item_in.op = gpht_pkg::OP_INSERT;
    end else begin
      item_in.op = gpht_pkg::OP_LOOKUP;
    end
  end

  gpht_fifo #(
    .WIDTH($bits(gpht_pkg::item_t)),
    .DEPTH(gpht_pkg::QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(item_in),
    .full_o (full),
    .pop_i  (pop_i),
    .rdata_o(item_o),
    .empty_o(empty_o)
  );

endmodule

/* hw/rtl/gpht_engine.sv */
// Back part: probes the key store a group at a time and updates the table.
// Depends on gpht_pkg and gpht_ram.
module gpht_engine #(
  parameter int SLOTS      = gpht_pkg::SLOTS_DEF,
  parameter int GROUP      = gpht_pkg::GROUP_DEF,
  parameter int VALUE_BITS = gpht_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [gpht_pkg::TBITS_W-1:0] table_bits_i,
  input  logic [gpht_pkg::LIMIT_W-1:0] load_limit_i,
  input  logic                         item_empty_i,
  input  gpht_pkg::item_t              item_i,
  output logic                         item_pop_o,
  input  logic                         res_full_i,
  output logic                         res_push_o,
  output gpht_pkg::out_word_t          res_o
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int OFF_W  = $clog2(GROUP);
  localparam int ROW_W  = IDX_W - OFF_W;
  localparam int ROWS   = SLOTS / GROUP;
  localparam int KEY_W  = gpht_pkg::KEY_W;
  localparam int ROWK_W = GROUP * KEY_W;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_VALUE = 3'd3;

  logic [2:0]                   state_q, state_d;
  logic [ROW_W-1:0]             sweep_q, sweep_d;
  logic                         reply_q, reply_d;
  logic [ROW_W-1:0]             row_q, row_d;
  logic [OFF_W-1:0]             off_q, off_d;
  logic [ROW_W:0]               left_q, left_d;
  logic [gpht_pkg::TOTAL_W-1:0] count_q, count_d;
  gpht_pkg::item_t              cur_q, cur_d;
  logic [IDX_W-1:0]             vslot_q, vslot_d;

  logic [4:0]        size_bits;
  logic [IDX_W-1:0]  idx_mask;
  logic [ROW_W-1:0]  row_mask;
  logic [ROW_W:0]    group_total;
  logic [IDX_W-1:0]  home;

  logic              k_we, k_re;
  logic [ROW_W-1:0]  k_waddr, k_raddr;
  logic [ROWK_W-1:0] k_wdata, k_rdata;
  logic              v_we, v_re;
  logic [IDX_W-1:0]  v_waddr, v_raddr;
  logic [VALUE_BITS-1:0] v_wdata, v_rdata;

  logic              hit_any, hit_match;
  logic [OFF_W-1:0]  hit_pos;
  logic [IDX_W-1:0]  hit_slot;

  // Table size clamped to GROUP..SLOTS.
  always_comb begin
    size_bits = 5'(table_bits_i);
    if (size_bits < 5'(OFF_W)) begin
      size_bits = 5'(OFF_W);
    end else if (size_bits > 5'(IDX_W)) begin
      size_bits = 5'(IDX_W);
    end
    idx_mask    = ~({IDX_W{1'b1}} << size_bits);
    row_mask    = idx_mask[IDX_W-1:OFF_W];
    group_total = (ROW_W+1)'(1) << (size_bits - 5'(OFF_W));
    home        = item_i.key[IDX_W-1:0] & idx_mask;
  end

  // Search the fetched group from the home offset, wrapping inside it.
  always_comb begin
    logic [OFF_W-1:0] pos;
    logic [KEY_W-1:0] k;
    hit_any   = 1'b0;
    hit_match = 1'b0;
    hit_pos   = '0;
    for (int s = 0; s < GROUP; s++) begin
      pos = off_q + OFF_W'(s);
      k   = k_rdata[pos*KEY_W +: KEY_W];
      if (!hit_any) begin
        if (k == cur_q.key) begin
          hit_any   = 1'b1;
          hit_match = 1'b1;
          hit_pos   = pos;
        end else if (&k) begin
          hit_any = 1'b1;
          hit_pos = pos;
        end
      end
    end
    hit_slot = {row_q, hit_pos};
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    reply_d    = reply_q;
    row_d      = row_q;
    off_d      = off_q;
    left_d     = left_q;
    count_d    = count_q;
    cur_d      = cur_q;
    vslot_d    = vslot_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    k_we       = 1'b0;
    k_waddr    = sweep_q;
    k_wdata    = '1;
    k_re       = 1'b0;
    k_raddr    = home[IDX_W-1:OFF_W];
    v_we       = 1'b0;
    v_waddr    = hit_slot;
    v_wdata    = VALUE_BITS'(cur_q.value);
    v_re       = 1'b0;
    v_raddr    = hit_slot;
    case (state_q)
      S_SWEEP: begin
        k_we    = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) begin
          state_d = S_IDLE;
          if (reply_q) begin
            count_d           = '0;
            res_push_o        = 1'b1;
            res_o.status      = gpht_pkg::ST_CLEARED;
            res_o.entry_total = '0;
          end
        end
      end
      S_IDLE: begin
        if (!item_empty_i && !res_full_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          row_d      = home[IDX_W-1:OFF_W];
          off_d      = home[OFF_W-1:0];
          left_d     = group_total;
          case (item_i.op)
            gpht_pkg::OP_CLEAR: begin
              state_d = S_SWEEP;
              sweep_d = '0;
              reply_d = 1'b1;
            end
            gpht_pkg::OP_RESERVED: begin
              res_push_o        = 1'b1;
              res_o.status      = gpht_pkg::ST_RESERVED;
              res_o.entry_total = count_q;
            end
            default: begin
              k_re    = 1'b1;
              state_d = S_CHECK;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (hit_any && hit_match) begin
          if (cur_q.op == gpht_pkg::OP_INSERT) begin
            v_we              = 1'b1;
            res_push_o        = 1'b1;
            res_o.status      = gpht_pkg::ST_REPLACED;
            res_o.slot_index  = gpht_pkg::SLOT_W'(hit_slot);
            res_o.entry_total = count_q;
            state_d           = S_IDLE;
          end else begin
            v_re    = 1'b1;
            vslot_d = hit_slot;
            state_d = S_VALUE;
          end
        end else if (hit_any) begin
          state_d           = S_IDLE;
          res_push_o        = 1'b1;
          res_o.entry_total = count_q;
          if (cur_q.op != gpht_pkg::OP_INSERT) begin
            res_o.status = gpht_pkg::ST_MISS;
          end else if (count_q < gpht_pkg::TOTAL_W'(load_limit_i)) begin
            k_we    = 1'b1;
            k_waddr = row_q;
            k_wdata = k_rdata;
            k_wdata[hit_pos*KEY_W +: KEY_W] = cur_q.key;
            v_we              = 1'b1;
            count_d           = count_q + 1'b1;
            res_o.status      = gpht_pkg::ST_INSERTED;
            res_o.slot_index  = gpht_pkg::SLOT_W'(hit_slot);
            res_o.entry_total = count_q + 1'b1;
          end else begin
            res_o.status = gpht_pkg::ST_FULL;
          end
        end else if (left_q == (ROW_W+1)'(1)) begin
          // Every slot in use visited without a match or a free slot.
          state_d           = S_IDLE;
          res_push_o        = 1'b1;
          res_o.entry_total = count_q;
          res_o.status      = (cur_q.op == gpht_pkg::OP_INSERT) ?
                              gpht_pkg::ST_FULL : gpht_pkg::ST_MISS;
        end else begin
          left_d  = left_q - 1'b1;
          row_d   = (row_q + 1'b1) & row_mask;
          k_re    = 1'b1;
          k_raddr = (row_q + 1'b1) & row_mask;
        end
      end
      S_VALUE: begin
        state_d           = S_IDLE;
        res_push_o        = 1'b1;
        res_o.status      = gpht_pkg::ST_HIT;
        res_o.found_value = gpht_pkg::VAL_W'(v_rdata);
        res_o.slot_index  = gpht_pkg::SLOT_W'(vslot_q);
        res_o.entry_total = count_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      reply_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      reply_q <= reply_d;
      count_q <= count_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    off_q   <= off_d;
    left_q  <= left_d;
    cur_q   <= cur_d;
    vslot_q <= vslot_d;
  end

  // Key store: one group of keys per row.
  gpht_ram #(
    .WIDTH(ROWK_W),
    .DEPTH(ROWS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (k_we),
    .waddr_i(k_waddr),
    .wdata_i(k_wdata),
    .re_i   (k_re),
    .raddr_i(k_raddr),
    .rdata_o(k_rdata)
  );

  // Value store: one value per slot.
  gpht_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(SLOTS)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_waddr),
    .wdata_i(v_wdata),
    .re_i   (v_re),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

endmodule

/* hw/rtl/grouped_probe_hash_table.sv */
// Top level of the grouped probe hash table.
// Depends on gpht_pkg, gpht_front, gpht_engine and gpht_fifo.
//
//   Channel   Handshake          Word
//   command   push / full        in_word_i  (cmd, key, value)
//   result    pop / empty        out_word_o (status, found_value, slot_index, entry_total)
//   config    cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// A lookup or insert reads the key store one group at a time, from the home
// group on, until a match, a free slot or the last group; a hit lookup then
// reads the value store. The key store port is read one group per cycle.
// Reset and clear both sweep the key store, one group row a cycle, over all
// rows of the key store; the engine takes no command word meanwhile, though
// the command queue still fills.
// Queues on both sides let the command side and the result side stall alone.
module grouped_probe_hash_table #(
  parameter int SLOTS      = gpht_pkg::SLOTS_DEF,
  parameter int GROUP      = gpht_pkg::GROUP_DEF,
  parameter int VALUE_BITS = gpht_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  gpht_pkg::in_word_t         in_word_i,
  output logic                       empty,
  input  logic                       pop,
  output gpht_pkg::out_word_t        out_word_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [gpht_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic [gpht_pkg::TBITS_W-1:0] table_bits_q;
  logic [gpht_pkg::LIMIT_W-1:0] load_limit_q;
  gpht_pkg::item_t              item;
  logic                         item_empty, item_pop;
  gpht_pkg::out_word_t          res;
  logic                         res_push, res_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_bits_q <= gpht_pkg::TBITS_RESET;
      load_limit_q <= gpht_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gpht_pkg::REG_TABLE_BITS) begin
        table_bits_q <= cfg_wdata_i[gpht_pkg::TBITS_W-1:0];
      end else begin
        load_limit_q <= cfg_wdata_i[gpht_pkg::LIMIT_W-1:0];
      end
    end
  end

  gpht_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .in_word_i(in_word_i),
    .full     (full),
    .pop_i    (item_pop),
    .item_o   (item),
    .empty_o  (item_empty)
  );

  gpht_engine #(
    .SLOTS     (SLOTS),
    .GROUP     (GROUP),
    .VALUE_BITS(VALUE_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .table_bits_i(table_bits_q),
    .load_limit_i(load_limit_q),
    .item_empty_i(item_empty),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue.
  gpht_fifo #(
    .WIDTH($bits(gpht_pkg::out_word_t)),
    .DEPTH(gpht_pkg::QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(out_word_o),
    .empty_o(empty)
  );

endmodule

/* tb/gpht_checker.sv */
// Checker for the grouped probe hash table: it watches the command, result and
// register ports, keeps its own copy of the table and compares every result word.
// Depends on gpht_pkg.
module gpht_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       full,
  input  gpht_pkg::in_word_t         in_word_i,
  input  logic                       empty,
  input  logic                       pop,
  input  gpht_pkg::out_word_t        out_word_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [gpht_pkg::CFG_W-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int NSLOTS = gpht_pkg::SLOTS_DEF;
  localparam int NGROUP = gpht_pkg::GROUP_DEF;
  localparam logic [gpht_pkg::KEY_W-1:0] VACANT = '1;

  logic [gpht_pkg::KEY_W-1:0]   slot_keys [NSLOTS];
  logic [gpht_pkg::VAL_W-1:0]   slot_vals [NSLOTS];
  logic [gpht_pkg::TOTAL_W-1:0] stored_count;
  logic [gpht_pkg::TBITS_W-1:0] tbits;
  logic [gpht_pkg::LIMIT_W-1:0] limit;
  gpht_pkg::out_word_t          result_queue [$];

  // Walk the home group from the home offset, then the following groups.
  // Returns 1 on a match, 2 at an empty slot, 0 when every slot was visited.
  function automatic int find_slot(logic [gpht_pkg::KEY_W-1:0] key, output int where);
    int size, mask, home, base, idx;
    size = 1 << tbits;
    if (size < NGROUP) size = NGROUP;
    if (size > NSLOTS) size = NSLOTS;
    mask = size - 1;
    home = int'(key[15:0]) & mask;
    base = home & ~(NGROUP - 1);
    where = 0;
    for (int g = 0; g < size / NGROUP; g++) begin
      for (int s = 0; s < NGROUP; s++) begin
        idx = (base | ((home + s) & (NGROUP - 1))) & mask;
        if (slot_keys[idx] == key) begin
          where = idx;
          return 1;
        end
        if (slot_keys[idx] == VACANT) begin
          where = idx;
          return 2;
        end
      end
      base = (base + NGROUP) & mask;
    end
    return 0;
  endfunction

  // Apply one command word to the table copy and give the result it causes.
  function automatic gpht_pkg::out_word_t apply_command(gpht_pkg::in_word_t w);
    gpht_pkg::out_word_t r;
    int where, hit;
    r = '0;
    if (w.cmd == gpht_pkg::CMD_CLEAR) begin
      foreach (slot_keys[i]) slot_keys[i] = VACANT;
      stored_count = '0;
      r.status = gpht_pkg::ST_CLEARED;
    end else if (w.key == VACANT) begin
      r.status = gpht_pkg::ST_RESERVED;
    end else if (w.cmd == gpht_pkg::CMD_INSERT) begin
      hit = find_slot(w.key, where);
      if (hit == 1) begin
        slot_vals[where] = w.value;
        r.status = gpht_pkg::ST_REPLACED;
        r.slot_index = where[gpht_pkg::SLOT_W-1:0];
      end else if (hit == 2 && stored_count < limit) begin
        slot_keys[where] = w.key;
        slot_vals[where] = w.value;
        stored_count = stored_count + 1'b1;
        r.status = gpht_pkg::ST_INSERTED;
        r.slot_index = where[gpht_pkg::SLOT_W-1:0];
      end else begin
        r.status = gpht_pkg::ST_FULL;
      end
    end else begin
      // Lookup, and the unused command, which acts as one.
      hit = find_slot(w.key, where);
      if (hit == 1) begin
        r.status = gpht_pkg::ST_HIT;
        r.found_value = slot_vals[where];
        r.slot_index = where[gpht_pkg::SLOT_W-1:0];
      end else begin
        r.status = gpht_pkg::ST_MISS;
      end
    end
    r.entry_total = stored_count;
    return r;
  endfunction

  // Sample all channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    gpht_pkg::out_word_t want;
    if (!rst_ni) begin
      foreach (slot_keys[i]) slot_keys[i] = VACANT;
      foreach (slot_vals[i]) slot_vals[i] = '0;
      stored_count = '0;
      tbits = gpht_pkg::TBITS_RESET;
      limit = gpht_pkg::LIMIT_RESET;
      result_queue.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == gpht_pkg::REG_TABLE_BITS) begin
          tbits = cfg_wdata_i[gpht_pkg::TBITS_W-1:0];
        end else begin
          limit = cfg_wdata_i[gpht_pkg::LIMIT_W-1:0];
        end
      end
      if (push && !full) result_queue.push_back(apply_command(in_word_i));
      if (pop && !empty) begin
        if (result_queue.size() == 0) begin
          $error("result word with nothing expected: %p", out_word_i);
          fail_count_o++;
        end else begin
          want = result_queue.pop_front();
          if (out_word_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word_i.status);
            fail_count_o++;
          end
          if (out_word_i.found_value !== want.found_value) begin
            $error("found_value: expected %h, got %h", want.found_value,
                   out_word_i.found_value);
            fail_count_o++;
          end
          if (out_word_i.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index,
                   out_word_i.slot_index);
            fail_count_o++;
          end
          if (out_word_i.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total,
                   out_word_i.entry_total);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = result_queue.size();
  end

endmodule

/* tb/grouped_probe_hash_table_test.sv */
// Top of the grouped probe hash table testbench: clock, reset, command stimulus,
// register settings and the verdict. Depends on gpht_pkg, gpht_checker and the block.
module grouped_probe_hash_table_test;

  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE = 200;
  localparam int RANDOM_PHASES = 10;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         push = 1'b0;
  logic                         full;
  gpht_pkg::in_word_t           in_word_i = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  gpht_pkg::out_word_t          out_word_o;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_idx_i = 1'b0;
  logic [gpht_pkg::CFG_W-1:0]   cfg_wdata_i = '0;
  int                           fail_count, pending, quiet_cycles;
  bit                           steady;
  logic [gpht_pkg::KEY_W-1:0]   key_pool [48];

  grouped_probe_hash_table dut (.*);

  gpht_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .in_word_i, .empty, .pop,
    .out_word_i(out_word_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: pop stalls in random bursts until the closing stretch.
  always @(negedge clk_i) begin
    int stall;
    if (stall > 0) begin
      stall--;
      pop <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(0, 12);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Stop the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one command word, with an optional random gap ahead of it.
  // Push stays high after the word is taken; the next call or the caller drops it.
  task automatic send(logic [1:0] cmd, logic [gpht_pkg::KEY_W-1:0] key,
                      logic [gpht_pkg::VAL_W-1:0] value);
    int gap;
    gap = (!steady && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_word_i <= '{cmd: cmd, key: key, value: value};
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Wait for the block to go idle, then set both registers.
  task automatic set_regs(logic [gpht_pkg::TBITS_W-1:0] tb,
                          logic [gpht_pkg::LIMIT_W-1:0] lim);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= gpht_pkg::REG_TABLE_BITS;
    cfg_wdata_i <= {6'($urandom), tb};
    @(negedge clk_i);
    cfg_idx_i <= gpht_pkg::REG_LOAD_LIMIT;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [gpht_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [gpht_pkg::TBITS_W-1:0] tb_set [RANDOM_PHASES] = '{0, 3, 3, 4, 5, 6, 10, 15, 7,
                                                             10};
    logic [gpht_pkg::LIMIT_W-1:0] lim_set [RANDOM_PHASES] = '{1023, 1, 6, 12, 1023, 0, 819,
                                                              1023, 100, 1023};
    int pick;
    logic [1:0] cmd;
    logic [gpht_pkg::KEY_W-1:0] key;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of the fields, every command, reserved key.
    send(gpht_pkg::CMD_LOOKUP, '0, '0);
    send(gpht_pkg::CMD_INSERT, '0, '0);
    send(gpht_pkg::CMD_INSERT, '0, '1);
    send(gpht_pkg::CMD_LOOKUP, '0, '0);
    send(gpht_pkg::CMD_INSERT, {gpht_pkg::KEY_W{1'b1}} - 1, 32'h5555_aaaa);
    send(gpht_pkg::CMD_LOOKUP, {gpht_pkg::KEY_W{1'b1}} - 1, '1);
    send(gpht_pkg::CMD_INSERT, '1, 32'h1234_5678);
    send(gpht_pkg::CMD_LOOKUP, '1, '0);
    send(2'd3, '0, '1);
    send(gpht_pkg::CMD_CLEAR, '1, '1);
    send(gpht_pkg::CMD_LOOKUP, '0, '0);

    // Small table with a high limit: fill every slot, then probe a table
    // with no empty slot, replace at the limit and resize with entries kept.
    set_regs(3, 1023);
    for (int i = 0; i < 8; i++) send(gpht_pkg::CMD_INSERT, 64'(i * 9 + 16), 32'(i));
    send(gpht_pkg::CMD_LOOKUP, 64'h100, '0);
    send(gpht_pkg::CMD_INSERT, 64'h100, '1);
    send(gpht_pkg::CMD_INSERT, 64'd16, 32'hdead_beef);
    set_regs(2, 8);
    send(gpht_pkg::CMD_LOOKUP, 64'd25, '0);
    send(gpht_pkg::CMD_INSERT, 64'd25, 32'h1);
    send(gpht_pkg::CMD_INSERT, 64'h200, '0);

    // Random phases over a range of settings, keys mostly from a pool so
    // that hits, replacements and long probe chains are common.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_regs(tb_set[p], lim_set[p]);
      foreach (key_pool[i]) begin
        key_pool[i] = rand_key();
        if ($urandom_range(0, 1)) key_pool[i][gpht_pkg::KEY_W-1:16] = '0;
      end
      if (p == RANDOM_PHASES - 1) steady = 1'b1;
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = gpht_pkg::CMD_INSERT;
        else if (pick < 95) cmd = gpht_pkg::CMD_LOOKUP;
        else if (pick < 97) cmd = gpht_pkg::CMD_CLEAR;
        else cmd = 2'd3;
        pick = $urandom_range(0, 99);
        if (pick < 80) key = key_pool[$urandom_range(0, 47)];
        else if (pick < 95) key = rand_key();
        else key = '1;
        send(cmd, key, $urandom);
      end
    end

    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
